FILE: design/wboa_pkg.sv
// ----------------------------------------------------------------------------
// wboa_pkg: shared types and constants of the windowed block overlap-add unit
// Field widths, command codes, configuration register indexes and their reset
// values, and the fixed-point constants of the weighting datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package wboa_pkg;

  // Default sizes of the image memory and the ramp table.
  localparam int DEF_MAX_ROWS     = 256;
  localparam int DEF_MAX_COLS     = 256;
  localparam int DEF_RAMP_ENTRIES = 1025;

  // Beat field widths.
  localparam int CMD_W     = 2;
  localparam int BIDX_W    = 8;
  localparam int PIDX_W    = 6;
  localparam int DATA_W    = 32;
  localparam int IMG_IDX_W = 8;

  // Configuration register widths.
  localparam int BS_W       = 7;
  localparam int DIM_W      = 9;
  localparam int PHASE_W    = 27;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 27;

  // Datapath widths.
  localparam int POS_W  = 15;  // image position, block index times step plus offset
  localparam int WGT_W  = 16;  // Q1.15 weight, 0 to 1.0 inclusive
  localparam int PROD_W = 49;  // sample times weight
  localparam int SUM_W  = 34;  // stored value plus term before saturation

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_ON    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_FIRST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_DOWN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_ACROSS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 3'd7;

  localparam logic [BS_W-1:0]    RST_BLOCK_SIZE    = 7'd8;
  localparam logic [DIM_W-1:0]   RST_IMAGE_ROWS    = 9'd256;
  localparam logic [DIM_W-1:0]   RST_IMAGE_COLS    = 9'd256;
  localparam logic [DIM_W-1:0]   RST_BLOCKS_DOWN   = 9'd1;
  localparam logic [DIM_W-1:0]   RST_BLOCKS_ACROSS = 9'd1;
  localparam logic [PHASE_W-1:0] RST_PHASE_STEP    = 27'd16777216;

  localparam logic [WGT_W-1:0] UNIT_Q15 = 16'h8000;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 34'sh0_7FFF_FFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -34'sh0_8000_0000;

endpackage

`default_nettype wire

FILE: design/wboa_if.sv
// ----------------------------------------------------------------------------
// wboa_if: valid/ready channels of the windowed block overlap-add unit
// One interface for the pixel beats going in and one for the results.
// ----------------------------------------------------------------------------
`default_nettype none

interface wboa_in_if
  import wboa_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic [CMD_W-1:0]            command;
  logic [BIDX_W-1:0]           block_row;
  logic [BIDX_W-1:0]           block_col;
  logic [PIDX_W-1:0]           row_in_block;
  logic [PIDX_W-1:0]           col_in_block;
  logic signed [DATA_W-1:0]    sample_value;
  logic [IMG_IDX_W-1:0]        read_row;
  logic [IMG_IDX_W-1:0]        read_col;

  modport source (
    output valid, command, block_row, block_col, row_in_block, col_in_block,
           sample_value, read_row, read_col,
    input  ready
  );
  modport sink (
    input  valid, command, block_row, block_col, row_in_block, col_in_block,
           sample_value, read_row, read_col,
    output ready
  );
endinterface

interface wboa_out_if
  import wboa_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pixel_value;
  logic                     in_bounds;

  modport source (output valid, pixel_value, in_bounds, input ready);
  modport sink (input valid, pixel_value, in_bounds, output ready);
endinterface

`default_nettype wire

FILE: design/wboa_ramp.sv
// ----------------------------------------------------------------------------
// wboa_ramp: sine-squared ramp ROM
// Q1.15 table of sin^2 over a quarter period, built at elaboration from a
// fixed-point Taylor series, with two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module wboa_ramp
  import wboa_pkg::*;
#(
  parameter int RAMP_ENTRIES = DEF_RAMP_ENTRIES,
  parameter int RAMP_AW      = $clog2(RAMP_ENTRIES)
) (
  input  wire logic               clk,
  input  wire logic               rd_en,
  input  wire logic [RAMP_AW-1:0] idx_a,
  input  wire logic [RAMP_AW-1:0] idx_b,
  output logic      [WGT_W-1:0]   data_a,
  output logic      [WGT_W-1:0]   data_b
);

  localparam int                 RAMP_LAST   = RAMP_ENTRIES - 1;
  localparam logic [63:0]        RAMP_LAST64 = 64'(RAMP_ENTRIES - 1);
  localparam logic [63:0]        PI_Q30      = 64'd3373259426;
  localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;
  localparam logic [63:0]        TAYLOR_DIV [9] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306
  };

  typedef logic [WGT_W-1:0] ramp_arr_t [RAMP_ENTRIES];

  // cos(x) for x in [0, pi/2], Q30 in and out.
  function automatic logic signed [63:0] cos_q30(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    x2   = (x * x) >> 30;
    term = 64'(ONE_Q30);
    acc  = ONE_Q30;
    for (int k = 0; k < 9; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k];
      if (k[0] == 1'b0) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = 64'sd0;
    end
    if (acc > ONE_Q30) begin
      acc = ONE_Q30;
    end
    return acc;
  endfunction

  // The upper half mirrors the lower one so that entry i and entry last-i
  // always sum to exactly 1.0.
  function automatic ramp_arr_t build_ramp();
    ramp_arr_t          tbl;
    logic [63:0]        x;
    logic signed [63:0] c;
    logic signed [63:0] v;
    for (int i = 0; i < RAMP_ENTRIES; i++) begin
      if (2 * i <= RAMP_LAST) begin
        x      = (64'(i) * PI_Q30) / RAMP_LAST64;
        c      = cos_q30(x);
        v      = ONE_Q30 - c + 64'sd32768;
        tbl[i] = WGT_W'(v >>> 16);
      end else begin
        tbl[i] = UNIT_Q15 - tbl[RAMP_LAST - i];
      end
    end
    return tbl;
  endfunction

  localparam ramp_arr_t RAMP_TABLE = build_ramp();

  logic [WGT_W-1:0] data_a_r;
  logic [WGT_W-1:0] data_b_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_a_r <= RAMP_TABLE[idx_a];
      data_b_r <= RAMP_TABLE[idx_b];
    end
  end

  assign data_a = data_a_r;
  assign data_b = data_b_r;

endmodule

`default_nettype wire

FILE: design/wboa_store.sv
// ----------------------------------------------------------------------------
// wboa_store: image memory
// Single-port synchronous RAM addressed by {row, column}; read data is
// registered and holds until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module wboa_store
  import wboa_pkg::*;
#(
  parameter int ROW_AW = $clog2(DEF_MAX_ROWS),
  parameter int COL_AW = $clog2(DEF_MAX_COLS)
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic                     wr_en,
  input  wire logic [ROW_AW+COL_AW-1:0] addr,
  input  wire logic [DATA_W-1:0]        wr_data,
  output logic      [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [2**(ROW_AW+COL_AW)];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: design/windowed_block_overlap_add_unit.sv
// ----------------------------------------------------------------------------
// windowed_block_overlap_add_unit: overlap-add image store with sine-squared
// edge weighting
// Places block pixels into an image memory (write, add or read back), with
// optional half-block overlap and Q1.15 ramp weighting of added pixels.
// ----------------------------------------------------------------------------
// A sequencer takes each pixel beat through its six states in order: the
// accepting idle state, address computation, one read of the image memory and
// the ramp ROM, weight product, sample scaling and the saturating sum with
// write-back. The sum step waits while the previous result is still held in
// the output register. One beat is in flight at a time, so a read never
// overlaps the write-back of an earlier beat. A result waits in an output
// register and the next beat is accepted while it waits. The image memory has
// no reset: a pixel must be written before it is read or added to.
`default_nettype none

module windowed_block_overlap_add_unit
  import wboa_pkg::*;
#(
  parameter int MAX_ROWS     = DEF_MAX_ROWS,
  parameter int MAX_COLS     = DEF_MAX_COLS,
  parameter int RAMP_ENTRIES = DEF_RAMP_ENTRIES
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  wboa_in_if.sink                    in_chan,
  wboa_out_if.source                 out_chan
);

  localparam int ROW_AW  = $clog2(MAX_ROWS);
  localparam int COL_AW  = $clog2(MAX_COLS);
  localparam int RAMP_AW = $clog2(RAMP_ENTRIES);
  localparam int RAMP_LAST = RAMP_ENTRIES - 1;
  localparam logic [POS_W-1:0]  ROW_LIMIT = POS_W'(MAX_ROWS);
  localparam logic [POS_W-1:0]  COL_LIMIT = POS_W'(MAX_COLS);
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(16384);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ADDR   = 6'b000010,
    ST_READ   = 6'b000100,
    ST_WEIGHT = 6'b001000,
    ST_SCALE  = 6'b010000,
    ST_SUM    = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    WSEL_RAMP,
    WSEL_INV,
    WSEL_UNIT,
    WSEL_ZERO
  } wsel_t;

  // Which weight a position gets along one axis.
  function automatic wsel_t weight_sel(input logic [PIDX_W-1:0] p,
                                       input logic [BIDX_W-1:0] b,
                                       input logic [DIM_W-1:0]  n,
                                       input logic [BS_W-1:0]   bs);
    logic [BS_W-1:0] half;
    logic            is_first;
    logic            is_last;
    logic            p_end;
    wsel_t           sel;
    half     = bs >> 1;
    is_first = (b == '0);
    is_last  = (DIM_W'(b) + DIM_W'(1) == n);
    p_end    = (BS_W'(p) + BS_W'(1) == bs);
    // An odd block has an edge pixel that is shared with the neighbor.
    if (!bs[0] || (p != '0 && !p_end)) begin
      if (!is_first && BS_W'(p) < half) begin
        sel = WSEL_RAMP;
      end else if (!is_last && BS_W'(p) > half) begin
        sel = WSEL_INV;
      end else begin
        sel = WSEL_UNIT;
      end
    end else if ((!is_first && p == '0) || (!is_last && p_end)) begin
      sel = WSEL_ZERO;
    end else begin
      sel = WSEL_UNIT;
    end
    return sel;
  endfunction

  // Ramp table index for a position, clamped to the last entry.
  function automatic logic [RAMP_AW-1:0] ramp_index(input logic [PIDX_W-1:0]  p,
                                                    input logic [BS_W-1:0]    bs,
                                                    input wsel_t              sel,
                                                    input logic [PHASE_W-1:0] phase);
    logic [PIDX_W-1:0]       off;
    logic [PHASE_W+PIDX_W-1:0] prod;
    logic [PHASE_W+PIDX_W-17:0] scaled;
    off = (sel == WSEL_INV) ? p - PIDX_W'(bs >> 1) : p;
    prod = (PHASE_W+PIDX_W)'(off) * (PHASE_W+PIDX_W)'(phase);
    scaled = prod[PHASE_W+PIDX_W-1:16];
    if (scaled > (PHASE_W+PIDX_W-16)'(RAMP_LAST)) begin
      scaled = (PHASE_W+PIDX_W-16)'(RAMP_LAST);
    end
    return RAMP_AW'(scaled);
  endfunction

  function automatic logic [WGT_W-1:0] axis_weight(input wsel_t sel,
                                                   input logic [WGT_W-1:0] ramp);
    logic [WGT_W-1:0] w;
    unique case (sel)
      WSEL_RAMP: w = ramp;
      WSEL_INV:  w = UNIT_Q15 - ramp;
      WSEL_UNIT: w = UNIT_Q15;
      WSEL_ZERO: w = '0;
      default:   w = '0;
    endcase
    return w;
  endfunction

  // Configuration registers.
  logic [BS_W-1:0]    bs_r;
  logic               overlap_r;
  logic               wfirst_r;
  logic [DIM_W-1:0]   img_rows_r;
  logic [DIM_W-1:0]   img_cols_r;
  logic [DIM_W-1:0]   blk_down_r;
  logic [DIM_W-1:0]   blk_across_r;
  logic [PHASE_W-1:0] phase_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r         <= RST_BLOCK_SIZE;
      overlap_r    <= 1'b0;
      wfirst_r     <= 1'b0;
      img_rows_r   <= RST_IMAGE_ROWS;
      img_cols_r   <= RST_IMAGE_COLS;
      blk_down_r   <= RST_BLOCKS_DOWN;
      blk_across_r <= RST_BLOCKS_ACROSS;
      phase_step_r <= RST_PHASE_STEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_SIZE:    bs_r         <= cfg_data[BS_W-1:0];
        CFG_OVERLAP_ON:    overlap_r    <= cfg_data[0];
        CFG_WEIGHT_FIRST:  wfirst_r     <= cfg_data[0];
        CFG_IMAGE_ROWS:    img_rows_r   <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_COLS:    img_cols_r   <= cfg_data[DIM_W-1:0];
        CFG_BLOCKS_DOWN:   blk_down_r   <= cfg_data[DIM_W-1:0];
        CFG_BLOCKS_ACROSS: blk_across_r <= cfg_data[DIM_W-1:0];
        CFG_PHASE_STEP:    phase_step_r <= cfg_data[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  state_t state_r, state_nxt;
  logic   accept;
  logic   sum_go;
  logic   out_valid_r;

  assign accept = in_chan.valid && in_chan.ready;
  assign sum_go = (state_r == ST_SUM) && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) begin state_nxt = ST_ADDR; end
      ST_ADDR:   state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_WEIGHT;
      ST_WEIGHT: state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_SUM;
      ST_SUM:    if (sum_go) begin state_nxt = ST_IDLE; end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Captured beat.
  cmd_t                     itm_cmd_r;
  logic [BIDX_W-1:0]        itm_brow_r;
  logic [BIDX_W-1:0]        itm_bcol_r;
  logic [PIDX_W-1:0]        itm_prow_r;
  logic [PIDX_W-1:0]        itm_pcol_r;
  logic signed [DATA_W-1:0] itm_sample_r;
  logic [IMG_IDX_W-1:0]     itm_rrow_r;
  logic [IMG_IDX_W-1:0]     itm_rcol_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      itm_cmd_r    <= cmd_t'(in_chan.command);
      itm_brow_r   <= in_chan.block_row;
      itm_bcol_r   <= in_chan.block_col;
      itm_prow_r   <= in_chan.row_in_block;
      itm_pcol_r   <= in_chan.col_in_block;
      itm_sample_r <= in_chan.sample_value;
      itm_rrow_r   <= in_chan.read_row;
      itm_rcol_r   <= in_chan.read_col;
    end
  end

  // Address step: image position, bounds and ramp indexes.
  logic [BS_W-1:0]  step;
  logic [POS_W-1:0] row_pos;
  logic [POS_W-1:0] col_pos;
  logic             cmd_read;
  logic             pos_ok;
  logic             in_img;
  wsel_t            wsel_row;
  wsel_t            wsel_col;

  assign cmd_read = (itm_cmd_r == CMD_READ);

  always_comb begin
    // (bs + 1) / 2 rounds up; bs itself may be odd.
    step = overlap_r ? bs_r - BS_W'(bs_r[BS_W-1:1] + BS_W'(bs_r[0])) : bs_r;
    if (cmd_read) begin
      row_pos = POS_W'(itm_rrow_r);
      col_pos = POS_W'(itm_rcol_r);
    end else begin
      row_pos = POS_W'(itm_brow_r) * POS_W'(step) + POS_W'(itm_prow_r);
      col_pos = POS_W'(itm_bcol_r) * POS_W'(step) + POS_W'(itm_pcol_r);
    end
    pos_ok = cmd_read || ((BS_W'(itm_prow_r) < bs_r) && (BS_W'(itm_pcol_r) < bs_r));
    in_img = (row_pos < POS_W'(img_rows_r)) && (row_pos < ROW_LIMIT) &&
             (col_pos < POS_W'(img_cols_r)) && (col_pos < COL_LIMIT);
    wsel_row = weight_sel(itm_prow_r, itm_brow_r, blk_down_r, bs_r);
    wsel_col = weight_sel(itm_pcol_r, itm_bcol_r, blk_across_r, bs_r);
  end

  logic [POS_W-1:0]   pos_row_r;
  logic [POS_W-1:0]   pos_col_r;
  logic               hit_r;
  logic               weighted_r;
  wsel_t              wsel_row_r;
  wsel_t              wsel_col_r;
  logic [RAMP_AW-1:0] ridx_row_r;
  logic [RAMP_AW-1:0] ridx_col_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_ADDR) begin
      pos_row_r  <= row_pos;
      pos_col_r  <= col_pos;
      hit_r      <= (itm_cmd_r != CMD_NONE) && pos_ok && in_img;
      weighted_r <= overlap_r && !wfirst_r;
      wsel_row_r <= wsel_row;
      wsel_col_r <= wsel_col;
      ridx_row_r <= ramp_index(itm_prow_r, bs_r, wsel_row, phase_step_r);
      ridx_col_r <= ramp_index(itm_pcol_r, bs_r, wsel_col, phase_step_r);
    end
  end

  // Image memory and ramp ROM, both read in the read step.
  logic                     mem_rd_en;
  logic                     mem_wr_en;
  logic [ROW_AW+COL_AW-1:0] mem_addr;
  logic [DATA_W-1:0]        mem_rd_data;
  logic [DATA_W-1:0]        mem_wr_data;
  logic [WGT_W-1:0]         ramp_row;
  logic [WGT_W-1:0]         ramp_col;

  assign mem_rd_en = (state_r == ST_READ);
  assign mem_addr  = {pos_row_r[ROW_AW-1:0], pos_col_r[COL_AW-1:0]};
  assign mem_wr_en = sum_go && hit_r &&
                     ((itm_cmd_r == CMD_WRITE) || (itm_cmd_r == CMD_ADD));

  wboa_store #(
    .ROW_AW (ROW_AW),
    .COL_AW (COL_AW)
  ) u_store (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .wr_en   (mem_wr_en),
    .addr    (mem_addr),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  wboa_ramp #(
    .RAMP_ENTRIES (RAMP_ENTRIES),
    .RAMP_AW      (RAMP_AW)
  ) u_ramp (
    .clk    (clk),
    .rd_en  (mem_rd_en),
    .idx_a  (ridx_row_r),
    .idx_b  (ridx_col_r),
    .data_a (ramp_row),
    .data_b (ramp_col)
  );

  // Weight step: combined Q1.15 weight, rounded.
  logic [2*WGT_W-1:0] w_prod;
  logic [WGT_W-1:0]   w_r;

  assign w_prod = (2*WGT_W)'(axis_weight(wsel_row_r, ramp_row)) *
                  (2*WGT_W)'(axis_weight(wsel_col_r, ramp_col)) + (2*WGT_W)'(16384);

  always_ff @(posedge clk) begin
    if (state_r == ST_WEIGHT) begin
      w_r <= WGT_W'(w_prod >> 15);
    end
  end

  // Scale step.
  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_SCALE) begin
      prod_r <= PROD_W'(itm_sample_r) * $signed(PROD_W'(w_r));
    end
  end

  // Sum step: an arithmetic shift floors the rounded product.
  logic signed [PROD_W-1:0] rounded;
  logic signed [SUM_W-1:0]  addend;
  logic signed [SUM_W-1:0]  total;
  logic signed [DATA_W-1:0] old_val;
  logic signed [DATA_W-1:0] sat_val;
  logic signed [DATA_W-1:0] new_val;
  logic signed [DATA_W-1:0] result;

  always_comb begin
    old_val = $signed(mem_rd_data);
    rounded = (prod_r + ROUND_HALF) >>> 15;
    addend  = weighted_r ? $signed(rounded[SUM_W-1:0]) : SUM_W'(itm_sample_r);
    total   = SUM_W'(old_val) + addend;
    if (total > SUM_MAX) begin
      sat_val = SUM_MAX[DATA_W-1:0];
    end else if (total < SUM_MIN) begin
      sat_val = SUM_MIN[DATA_W-1:0];
    end else begin
      sat_val = total[DATA_W-1:0];
    end
    new_val = (itm_cmd_r == CMD_WRITE) ? itm_sample_r : sat_val;
    result  = cmd_read ? old_val : new_val;
  end

  assign mem_wr_data = new_val;

  // Output register.
  logic signed [DATA_W-1:0] out_pixel_r;
  logic                     out_inb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sum_go) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_go) begin
      out_pixel_r <= hit_r ? result : '0;
      out_inb_r   <= hit_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.pixel_value = out_pixel_r;
  assign out_chan.in_bounds   = out_inb_r;

endmodule

`default_nettype wire
